>>> hw/rtl/efp_pkg.sv
// Shared types, widths and helpers for the escape-time fractal pixel block.
// Depends on nothing; every other file in hw/rtl imports it.
`default_nettype none

package efp_pkg;

    // Fixed-point layout: signed Q4.28 for plane values.
    localparam int FIX_W   = 32;
    localparam int FRAC_W  = 28;
    localparam int WIDE_W  = 64;
    localparam int MAG_W   = WIDE_W - FRAC_W;
    localparam int PIX_W   = 10;
    localparam int ITER_W  = 16;
    localparam int SCALE_W = 31;
    localparam int BAIL_W  = 31;

    // Seed queue between the front and the iteration unit.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Saturation bounds, sign-extended to the wide product width.
    localparam logic signed [WIDE_W-1:0] FIX_MAX_EXT = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] FIX_MIN_EXT = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [FIX_W-1:0]  FIX_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [FIX_W-1:0]  FIX_MIN     = 32'sh8000_0000;

    // Register indexes of the configuration write port.
    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_CENTER_RE = 3'd1,
        REG_CENTER_IM = 3'd2,
        REG_SCALE     = 3'd3,
        REG_JULIA_RE  = 3'd4,
        REG_JULIA_IM  = 3'd5,
        REG_MAX_ITER  = 3'd6,
        REG_BAILOUT   = 3'd7
    } efp_reg_t;

    // Configuration register file contents.
    typedef struct packed {
        logic                     mode;
        logic signed [FIX_W-1:0]  center_re;
        logic signed [FIX_W-1:0]  center_im;
        logic [SCALE_W-1:0]       scale;
        logic signed [FIX_W-1:0]  julia_re;
        logic signed [FIX_W-1:0]  julia_im;
        logic [ITER_W-1:0]        max_iter;
        logic [BAIL_W-1:0]        bailout;
    } efp_cfg_t;

    // Starting point of one pixel's orbit: initial z and the constant c.
    typedef struct packed {
        logic signed [FIX_W-1:0] z_re;
        logic signed [FIX_W-1:0] z_im;
        logic signed [FIX_W-1:0] c_re;
        logic signed [FIX_W-1:0] c_im;
    } efp_seed_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [WIDE_W-1:0] v);
        if (v > FIX_MAX_EXT) begin
            return FIX_MAX;
        end
        else if (v < FIX_MIN_EXT) begin
            return FIX_MIN;
        end
        else begin
            return $signed(v[FIX_W-1:0]);
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/efp_front.sv
// Front end: takes pixel beats, maps them onto the complex plane and forms the seed.
// Depends on efp_pkg; feeds efp_queue.
`default_nettype none

module efp_front #(
    parameter int IMAGE_COLS = 1024,
    parameter int IMAGE_ROWS = 768
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire efp_pkg::efp_cfg_t          cfg,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [efp_pkg::PIX_W-1:0]  pixel_x,
    input  wire logic [efp_pkg::PIX_W-1:0]  pixel_y,
    input  wire logic                       q_full,
    output logic                            q_push,
    output efp_pkg::efp_seed_t              q_seed
);
    import efp_pkg::*;

    localparam int HALF_COLS = IMAGE_COLS / 2;
    localparam int HALF_ROWS = IMAGE_ROWS / 2;
    localparam int SPAN      = (IMAGE_COLS > IMAGE_ROWS) ? IMAGE_COLS : IMAGE_ROWS;
    localparam int D_W       = $clog2(SPAN / 2 + (1 << PIX_W)) + 1;
    localparam int P_W       = D_W + SCALE_W + 1;

    logic                   v1_reg;
    logic                   v1_next;
    logic [PIX_W-1:0]       px_reg;
    logic [PIX_W-1:0]       py_reg;
    logic                   v2_reg;
    logic                   v2_next;
    logic signed [P_W-1:0]  prod_re_reg;
    logic signed [P_W-1:0]  prod_im_reg;
    logic signed [P_W-1:0]  prod_re_next;
    logic signed [P_W-1:0]  prod_im_next;

    logic                   accept;
    logic                   s2_load;
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic signed [FIX_W:0]  scale_s;
    logic signed [FIX_W-1:0] off_re;
    logic signed [FIX_W-1:0] off_im;

    // Stage handshakes: stage two drains into the queue, stage one into stage two.
    assign q_push  = v2_reg && !q_full;
    assign s2_load = v1_reg && (!v2_reg || q_push);
    assign busy    = v1_reg && !s2_load;
    assign accept  = start && !busy;

    assign v1_next = accept ? 1'b1 : (s2_load ? 1'b0 : v1_reg);
    assign v2_next = s2_load ? 1'b1 : (q_push ? 1'b0 : v2_reg);

    // Pixel offset from the image center, then scaled into plane units.
    assign dx      = $signed(D_W'(px_reg)) - $signed(D_W'(HALF_COLS));
    assign dy      = $signed(D_W'(py_reg)) - $signed(D_W'(HALF_ROWS));
    assign scale_s = $signed({2'b00, cfg.scale});

    assign prod_re_next = P_W'(dx) * P_W'(scale_s);
    assign prod_im_next = P_W'(dy) * P_W'(scale_s);

    // Seed forming: Julia starts at the offset, Mandelbrot at zero.
    assign off_re = sat_fix(WIDE_W'(prod_re_reg));
    assign off_im = sat_fix(WIDE_W'(prod_im_reg));

    always_comb
    begin
        if (cfg.mode)
        begin
            q_seed.z_re = off_re;
            q_seed.z_im = off_im;
            q_seed.c_re = cfg.julia_re;
            q_seed.c_im = cfg.julia_im;
        end
        else
        begin
            q_seed.z_re = '0;
            q_seed.z_im = '0;
            q_seed.c_re = sat_fix(WIDE_W'(cfg.center_re) + WIDE_W'(off_re));
            q_seed.c_im = sat_fix(WIDE_W'(cfg.center_im) + WIDE_W'(off_im));
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (s2_load)
        begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/efp_queue.sv
// Short seed queue that decouples the front end from the iteration unit.
// Depends on efp_pkg for the seed type and the queue depth.
`default_nettype none

module efp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire efp_pkg::efp_seed_t  wr_data,
    output logic                     full,
    input  wire logic                rd_en,
    output efp_pkg::efp_seed_t       rd_data,
    output logic                     empty
);
    import efp_pkg::*;

    efp_seed_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_CW-1:0]    count_reg;
    logic [QUEUE_AW-1:0]    wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_next;
    logic [QUEUE_CW-1:0]    count_next;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("seed queue written while full");

    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("seed queue read while empty");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("seed queue fill count out of range");

endmodule

`default_nettype wire

>>> hw/rtl/efp_back.sv
// Iteration unit: runs z = z*z + c on one seed until escape or the iteration limit.
// Depends on efp_pkg; pops seeds from efp_queue and drives the result beat.
`default_nettype none

module efp_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire efp_pkg::efp_cfg_t             cfg,
    input  wire logic                          q_empty,
    input  wire efp_pkg::efp_seed_t            q_data,
    output logic                               q_pop,
    output logic                               done,
    output logic [efp_pkg::ITER_W-1:0]         iterations,
    output logic                               escaped,
    output logic signed [efp_pkg::FIX_W-1:0]   final_re,
    output logic signed [efp_pkg::FIX_W-1:0]   final_im
);
    import efp_pkg::*;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_MUL  = 3'b010,
        BK_UPD  = 3'b100
    } bk_state_t;

    bk_state_t                state_reg;
    bk_state_t                state_next;
    logic                     first_reg;
    logic                     first_next;
    logic [ITER_W-1:0]        cnt_reg;
    logic [ITER_W-1:0]        cnt_next;
    logic                     done_reg;
    logic                     done_next;

    logic signed [FIX_W-1:0]  z_re_reg;
    logic signed [FIX_W-1:0]  z_im_reg;
    logic signed [FIX_W-1:0]  c_re_reg;
    logic signed [FIX_W-1:0]  c_im_reg;
    logic signed [FIX_W-1:0]  z_re_next;
    logic signed [FIX_W-1:0]  z_im_next;
    logic signed [FIX_W-1:0]  c_re_next;
    logic signed [FIX_W-1:0]  c_im_next;
    logic signed [WIDE_W-1:0] rr_reg;
    logic signed [WIDE_W-1:0] ii_reg;
    logic signed [WIDE_W-1:0] ri_reg;
    logic signed [WIDE_W-1:0] rr_next;
    logic signed [WIDE_W-1:0] ii_next;
    logic signed [WIDE_W-1:0] ri_next;
    logic [ITER_W-1:0]        iter_reg;
    logic [ITER_W-1:0]        iter_next;
    logic                     esc_reg;
    logic                     esc_next;
    logic signed [FIX_W-1:0]  fre_reg;
    logic signed [FIX_W-1:0]  fim_reg;
    logic signed [FIX_W-1:0]  fre_next;
    logic signed [FIX_W-1:0]  fim_next;

    logic signed [WIDE_W-1:0] diff;
    logic signed [WIDE_W-1:0] re_sum;
    logic signed [WIDE_W-1:0] im_sum;
    logic signed [FIX_W-1:0]  new_re;
    logic signed [FIX_W-1:0]  new_im;
    logic [WIDE_W-1:0]        mag;
    logic                     esc_hit;
    logic [ITER_W-1:0]        cnt_inc;
    logic                     at_limit;

    // Next z from the registered squares; the floor comes from the arithmetic shift.
    assign diff   = rr_reg - ii_reg;
    assign re_sum = (diff >>> FRAC_W) + WIDE_W'(c_re_reg);
    assign im_sum = (ri_reg >>> (FRAC_W - 1)) + WIDE_W'(c_im_reg);
    assign new_re = sat_fix(re_sum);
    assign new_im = sat_fix(im_sum);

    // Squared magnitude of the current z reuses the squares of the next step.
    assign mag      = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign esc_hit  = mag[WIDE_W-1:FRAC_W] > MAG_W'(cfg.bailout);
    assign cnt_inc  = cnt_reg + ITER_W'(1);
    assign at_limit = (cnt_inc == cfg.max_iter);

    assign done       = done_reg;
    assign iterations = iter_reg;
    assign escaped    = esc_reg;
    assign final_re   = fre_reg;
    assign final_im   = fim_reg;

    // Sequencer: a square step and an update step per iteration.
    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        q_pop      = 1'b0;
        z_re_next  = z_re_reg;
        z_im_next  = z_im_reg;
        c_re_next  = c_re_reg;
        c_im_next  = c_im_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        ri_next    = ri_reg;
        iter_next  = iter_reg;
        esc_next   = esc_reg;
        fre_next   = fre_reg;
        fim_next   = fim_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    z_re_next  = q_data.z_re;
                    z_im_next  = q_data.z_im;
                    c_re_next  = q_data.c_re;
                    c_im_next  = q_data.c_im;
                    cnt_next   = '0;
                    first_next = 1'b1;
                    if (cfg.max_iter == '0)
                    begin
                        // No iteration at all: report the starting point.
                        done_next = 1'b1;
                        iter_next = '0;
                        esc_next  = 1'b0;
                        fre_next  = q_data.z_re;
                        fim_next  = q_data.z_im;
                    end
                    else
                    begin
                        state_next = BK_MUL;
                    end
                end
            end

            BK_MUL:
            begin
                rr_next    = WIDE_W'(z_re_reg) * WIDE_W'(z_re_reg);
                ii_next    = WIDE_W'(z_im_reg) * WIDE_W'(z_im_reg);
                ri_next    = WIDE_W'(z_re_reg) * WIDE_W'(z_im_reg);
                state_next = BK_UPD;
            end

            BK_UPD:
            begin
                if (first_reg)
                begin
                    // The starting z is never tested, only stepped.
                    first_next = 1'b0;
                    z_re_next  = new_re;
                    z_im_next  = new_im;
                    state_next = BK_MUL;
                end
                else if (esc_hit)
                begin
                    done_next  = 1'b1;
                    iter_next  = cnt_reg;
                    esc_next   = 1'b1;
                    fre_next   = z_re_reg;
                    fim_next   = z_im_reg;
                    state_next = BK_IDLE;
                end
                else if (at_limit)
                begin
                    done_next  = 1'b1;
                    iter_next  = cnt_inc;
                    esc_next   = 1'b0;
                    fre_next   = z_re_reg;
                    fim_next   = z_im_reg;
                    state_next = BK_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    z_re_next  = new_re;
                    z_im_next  = new_im;
                    state_next = BK_MUL;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        z_re_reg <= z_re_next;
        z_im_reg <= z_im_next;
        c_re_reg <= c_re_next;
        c_im_reg <= c_im_next;
        rr_reg   <= rr_next;
        ii_reg   <= ii_next;
        ri_reg   <= ri_next;
        iter_reg <= iter_next;
        esc_reg  <= esc_next;
        fre_reg  <= fre_next;
        fim_reg  <= fim_next;
    end

    a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_MUL |=> state_reg == BK_UPD)
        else $error("square step not followed by update step");

    a_escape_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && esc_reg |-> $past(state_reg == BK_UPD))
        else $error("escape reported outside the update step");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == BK_IDLE)
        else $error("seed taken while an orbit is running");

endmodule

`default_nettype wire

>>> hw/rtl/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel block: configuration registers,
// front end, seed queue and iteration unit. Depends on efp_pkg and all efp_* modules.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+------------------------------------------
//   config   | cfg_we              | cfg_index, cfg_data
//   pixel    | start && !busy      | pixel_x, pixel_y
//   result   | done (one cycle)    | iterations, escaped, final_re, final_im
//
// A pixel beat passes the front end's pixel and product stages before its seed is queued.
// The iteration unit pops a seed, then runs a square step and an update step for each
// iteration until the orbit escapes or reaches the limit.
// Reset clears the configuration to its defaults and empties the queue and the pipeline.
// The result receiver cannot stall; busy rises only when the front end and queue are full.
`default_nettype none

module escape_time_fractal_pixel #(
    parameter int IMAGE_COLS = 1024,
    parameter int IMAGE_ROWS = 768
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [efp_pkg::FIX_W-1:0]     cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [efp_pkg::PIX_W-1:0]     pixel_x,
    input  wire logic [efp_pkg::PIX_W-1:0]     pixel_y,
    output logic                               done,
    output logic [efp_pkg::ITER_W-1:0]         iterations,
    output logic                               escaped,
    output logic signed [efp_pkg::FIX_W-1:0]   final_re,
    output logic signed [efp_pkg::FIX_W-1:0]   final_im
);
    import efp_pkg::*;

    efp_cfg_t   cfg_reg;
    efp_cfg_t   cfg_next;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    efp_seed_t  q_wr_seed;
    efp_seed_t  q_rd_seed;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:      cfg_next.mode      = cfg_data[0];
                REG_CENTER_RE: cfg_next.center_re = $signed(cfg_data);
                REG_CENTER_IM: cfg_next.center_im = $signed(cfg_data);
                REG_SCALE:     cfg_next.scale     = cfg_data[SCALE_W-1:0];
                REG_JULIA_RE:  cfg_next.julia_re  = $signed(cfg_data);
                REG_JULIA_IM:  cfg_next.julia_im  = $signed(cfg_data);
                REG_MAX_ITER:  cfg_next.max_iter  = cfg_data[ITER_W-1:0];
                REG_BAILOUT:   cfg_next.bailout   = cfg_data[BAIL_W-1:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= 1'b0;
            cfg_reg.center_re <= '0;
            cfg_reg.center_im <= '0;
            cfg_reg.scale     <= SCALE_W'(1048576);
            cfg_reg.julia_re  <= '0;
            cfg_reg.julia_im  <= '0;
            cfg_reg.max_iter  <= ITER_W'(256);
            cfg_reg.bailout   <= BAIL_W'(1073741824);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: pixel to seed.
    efp_front #(
        .IMAGE_COLS (IMAGE_COLS),
        .IMAGE_ROWS (IMAGE_ROWS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .start   (start),
        .busy    (busy),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_seed  (q_wr_seed)
    );

    // Seed queue.
    efp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_seed),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_seed),
        .empty   (q_empty)
    );

    // Iteration unit and result beat.
    efp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_data     (q_rd_seed),
        .q_pop      (q_pop),
        .done       (done),
        .iterations (iterations),
        .escaped    (escaped),
        .final_re   (final_re),
        .final_im   (final_im)
    );

endmodule

`default_nettype wire

>>> dv/tb_escape_time_fractal_pixel.sv
// Self-checking testbench for escape_time_fractal_pixel: directed and random pixels
// under many register settings, checked against an in-bench orbit predictor.
// Depends on efp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_escape_time_fractal_pixel;

    import efp_pkg::*;

    localparam int IMAGE_COLS     = 1024;
    localparam int IMAGE_ROWS     = 768;
    localparam int WATCHDOG_LIMIT = 500000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PIXELS   = 100;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic {
        MODE_MANDELBROT = 1'b0,
        MODE_JULIA      = 1'b1
    } fractal_mode_t;

    // One result beat of the block.
    typedef struct packed {
        logic [ITER_W-1:0]       iterations;
        logic                    escaped;
        logic signed [FIX_W-1:0] final_re;
        logic signed [FIX_W-1:0] final_im;
    } pixel_outcome_t;

    // Predicts each pixel's orbit and matches result beats against the predictions.
    class pixel_scoreboard;
        efp_cfg_t       settings;
        pixel_outcome_t pending[$];
        int             mismatches;

        function new();
            settings.mode      = MODE_MANDELBROT;
            settings.center_re = '0;
            settings.center_im = '0;
            settings.scale     = 31'd1048576;
            settings.julia_re  = '0;
            settings.julia_im  = '0;
            settings.max_iter  = 16'd256;
            settings.bailout   = 31'd1073741824;
            mismatches         = 0;
        endfunction

        function logic signed [FIX_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647) begin
                return 32'sh7FFF_FFFF;
            end
            else if (v < -64'sd2147483648) begin
                return 32'sh8000_0000;
            end
            return v[FIX_W-1:0];
        endfunction

        // Walks z = z*z + c until the squared magnitude passes the bailout or the limit.
        function pixel_outcome_t iterate_orbit(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            pixel_outcome_t          r;
            longint                  dx;
            longint                  dy;
            longint                  rr;
            longint                  ii;
            longint                  ri;
            longint unsigned         sq_re;
            longint unsigned         sq_im;
            logic signed [FIX_W-1:0] off_re;
            logic signed [FIX_W-1:0] off_im;
            logic signed [FIX_W-1:0] zr;
            logic signed [FIX_W-1:0] zi;
            logic signed [FIX_W-1:0] cr;
            logic signed [FIX_W-1:0] ci;
            int unsigned             n;

            dx     = longint'(px) - IMAGE_COLS / 2;
            dy     = longint'(py) - IMAGE_ROWS / 2;
            off_re = clamp32(dx * longint'(settings.scale));
            off_im = clamp32(dy * longint'(settings.scale));
            if (settings.mode == MODE_JULIA) begin
                zr = off_re;
                zi = off_im;
                cr = settings.julia_re;
                ci = settings.julia_im;
            end
            else begin
                zr = '0;
                zi = '0;
                cr = clamp32(longint'(settings.center_re) + longint'(off_re));
                ci = clamp32(longint'(settings.center_im) + longint'(off_im));
            end
            r.escaped = 1'b0;
            n = 0;
            while (n < settings.max_iter) begin
                rr = longint'(zr) * longint'(zr);
                ii = longint'(zi) * longint'(zi);
                ri = longint'(zr) * longint'(zi);
                // Arithmetic shifts give the floor of the scaled products.
                zr = clamp32(((rr - ii) >>> FRAC_W) + longint'(cr));
                zi = clamp32((ri >>> (FRAC_W - 1)) + longint'(ci));
                sq_re = longint'(zr) * longint'(zr);
                sq_im = longint'(zi) * longint'(zi);
                if (((sq_re + sq_im) >> FRAC_W) > settings.bailout) begin
                    r.escaped = 1'b1;
                    break;
                end
                n++;
            end
            r.iterations = n[ITER_W-1:0];
            r.final_re   = zr;
            r.final_im   = zi;
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            pending.push_back(iterate_orbit(px, py));
        endfunction

        function void check_result(pixel_outcome_t got);
            pixel_outcome_t want;

            if (pending.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: result beat with no pixel pending: %s",
                             $realtime, "unexpected beat");
                    $display("    it=%0d esc=%0b re=%h im=%h",
                             got.iterations, got.escaped, got.final_re, got.final_im);
                end
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.iterations !== want.iterations || got.escaped !== want.escaped ||
                got.final_re !== want.final_re || got.final_im !== want.final_im) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: result mismatch: iterations exp %0d got %0d,",
                             $realtime, want.iterations, got.iterations);
                    $display("    escaped exp %0b got %0b", want.escaped, got.escaped);
                    $display("    final_re exp %h got %h, final_im exp %h got %h",
                             want.final_re, got.final_re, want.final_im, got.final_im);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [2:0]              cfg_index;
    logic [FIX_W-1:0]        cfg_data;
    logic                    start;
    logic                    busy;
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
    logic                    done;
    logic [ITER_W-1:0]       iterations;
    logic                    escaped;
    logic signed [FIX_W-1:0] final_re;
    logic signed [FIX_W-1:0] final_im;

    pixel_scoreboard sb = new();

    escape_time_fractal_pixel #(
        .IMAGE_COLS (IMAGE_COLS),
        .IMAGE_ROWS (IMAGE_ROWS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .done       (done),
        .iterations (iterations),
        .escaped    (escaped),
        .final_re   (final_re),
        .final_im   (final_im)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Beats are sampled mid-cycle, where every handshake signal is stable.
    always @(negedge clk)
    begin
        if (rst_n && done) begin
            sb.check_result('{iterations, escaped, final_re, final_im});
        end
        if (rst_n && start && !busy) begin
            sb.note_pixel(pixel_x, pixel_y);
        end
    end

    // Ends the run when no beat has moved on either side for too long.
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((rst_n && start && !busy) || (rst_n && done)) begin
                quiet = 0;
            end
            else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic efp_cfg_t settings_of(logic m, logic signed [FIX_W-1:0] cre,
                                             logic signed [FIX_W-1:0] cim,
                                             logic [SCALE_W-1:0] scl,
                                             logic signed [FIX_W-1:0] jre,
                                             logic signed [FIX_W-1:0] jim,
                                             logic [ITER_W-1:0] lim,
                                             logic [BAIL_W-1:0] bail);
        efp_cfg_t s;

        s.mode      = m;
        s.center_re = cre;
        s.center_im = cim;
        s.scale     = scl;
        s.julia_re  = jre;
        s.julia_im  = jim;
        s.max_iter  = lim;
        s.bailout   = bail;
        return s;
    endfunction

    // Drops start and waits until every accepted pixel has produced its result.
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(efp_reg_t idx, logic [FIX_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes the whole register file while the block is idle.
    task automatic load_settings(efp_cfg_t s);
        wait_idle();
        write_reg(REG_MODE, {31'd0, s.mode});
        write_reg(REG_CENTER_RE, s.center_re);
        write_reg(REG_CENTER_IM, s.center_im);
        write_reg(REG_SCALE, {1'b0, s.scale});
        write_reg(REG_JULIA_RE, s.julia_re);
        write_reg(REG_JULIA_IM, s.julia_im);
        write_reg(REG_MAX_ITER, {16'd0, s.max_iter});
        write_reg(REG_BAILOUT, {1'b0, s.bailout});
        cfg_we <= 1'b0;
        sb.settings = s;
    endtask

    // Offers one pixel beat, with an optional gap first, and returns once it is taken.
    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, int gap_pct);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        @(negedge clk);
        while (busy) begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin : stimulus
        efp_cfg_t         s;
        int               k;
        int               gap_pct;
        logic [PIX_W-1:0] py;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_MODE;
        cfg_data  = '0;
        start     = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: image corners, the centre and rows beyond the image.
        send_pixel(10'd512, 10'd384, 0);
        send_pixel(10'd0, 10'd0, 0);
        send_pixel(10'd1023, 10'd767, 0);
        send_pixel(10'd1023, 10'd1023, 0);
        send_pixel(10'd0, 10'd1023, 0);

        // Zero iteration limit in both modes: the starting z comes back untouched.
        load_settings(settings_of(MODE_MANDELBROT, 32'sh0800_0000, -32'sh0400_0000,
                                  31'd1048576, '0, '0, 16'd0, 31'd1073741824));
        send_pixel(10'd100, 10'd200, 0);
        load_settings(settings_of(MODE_JULIA, '0, '0, 31'd1048576, 32'sh0400_0000,
                                  32'sh0400_0000, 16'd0, 31'd1073741824));
        send_pixel(10'd0, 10'd0, 0);

        // Zero scale and zero bailout: a squared magnitude of one or more escapes.
        load_settings(settings_of(MODE_MANDELBROT, 32'sh0800_0000, 32'sh0800_0000, 31'd0,
                                  '0, '0, 16'd8, 31'd0));
        send_pixel(10'd0, 10'd0, 0);
        send_pixel(10'd512, 10'd384, 0);
        load_settings(settings_of(MODE_MANDELBROT, '0, '0, 31'd0, '0, '0, 16'd8, 31'd0));
        send_pixel(10'd700, 10'd10, 0);

        // Largest scale and centre: offsets and c saturate.
        load_settings(settings_of(MODE_MANDELBROT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                  31'h7FFF_FFFF, '0, '0, 16'd4, 31'h7FFF_FFFF));
        send_pixel(10'd1023, 10'd1023, 0);
        send_pixel(10'd0, 10'd0, 0);
        send_pixel(10'd512, 10'd384, 0);

        // Julia mode at the negative extremes; the centre must be ignored.
        load_settings(settings_of(MODE_JULIA, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
                                  32'sh8000_0000, 32'sh8000_0000, 16'd4, 31'h7FFF_FFFF));
        send_pixel(10'd0, 10'd0, 0);
        send_pixel(10'd1023, 10'd767, 0);
        send_pixel(10'd512, 10'd384, 0);

        // A classic connected Julia set around a small window.
        load_settings(settings_of(MODE_JULIA, '0, '0, 31'd1048576, -32'sd214748365,
                                  32'sd41875931, 16'd64, 31'd1073741824));
        send_pixel(10'd512, 10'd384, 0);
        send_pixel(10'd300, 10'd500, 0);

        // Largest iteration limit: one orbit that never escapes, one that leaves fast.
        load_settings(settings_of(MODE_MANDELBROT, '0, '0, 31'd1048576, '0, '0,
                                  16'hFFFF, 31'd1073741824));
        send_pixel(10'd0, 10'd0, 0);
        send_pixel(10'd512, 10'd384, 0);

        // Random settings and pixels; sender gaps vary by thirds of the run.
        k = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            s.mode = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 7) begin
                // Views near the interesting part of the plane.
                s.center_re = int'($urandom_range(0, 1 << 30)) - (1 << 29);
                s.center_im = int'($urandom_range(0, 1 << 30)) - (1 << 29);
                s.scale     = SCALE_W'($urandom_range(1 << 12, 1 << 21));
                s.julia_re  = int'($urandom_range(0, 1 << 29)) - (1 << 28);
                s.julia_im  = int'($urandom_range(0, 1 << 29)) - (1 << 28);
                s.bailout   = $urandom_range(0, 1) ? 31'd1073741824 : 31'($urandom);
            end
            else begin
                s.center_re = $urandom;
                s.center_im = $urandom;
                s.scale     = 31'($urandom);
                s.julia_re  = $urandom;
                s.julia_im  = $urandom;
                s.bailout   = 31'($urandom);
            end
            case ($urandom_range(0, 9))
                0:       s.max_iter = ITER_W'($urandom_range(0, 2));
                8, 9:    s.max_iter = ITER_W'($urandom_range(41, 200));
                default: s.max_iter = ITER_W'($urandom_range(1, 40));
            endcase
            load_settings(s);
            for (int i = 0; i < PHASE_PIXELS; i++) begin
                if (k < RANDOM_PHASES * PHASE_PIXELS / 3) begin
                    gap_pct = 7;
                end
                else if (k < 2 * RANDOM_PHASES * PHASE_PIXELS / 3) begin
                    gap_pct = 66;
                end
                else begin
                    gap_pct = 0;
                end
                // Most rows lie inside the image, some beyond it.
                py = ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(0, 1023))
                                                 : PIX_W'($urandom_range(0, IMAGE_ROWS - 1));
                send_pixel(PIX_W'($urandom_range(0, 1023)), py, gap_pct);
                k++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/efp_pkg.sv
hw/rtl/efp_front.sv
hw/rtl/efp_queue.sv
hw/rtl/efp_back.sv
hw/rtl/escape_time_fractal_pixel.sv
dv/tb_escape_time_fractal_pixel.sv
